[sv/tcw_pkg.sv]
package tcw_pkg;

    // Default screen geometry
    localparam int unsigned DEF_COLUMNS = 80;
    localparam int unsigned DEF_ROWS    = 25;

    // Fixed field widths
    localparam int unsigned CH_W   = 8;
    localparam int unsigned ATTR_W = 8;
    localparam int unsigned IDX_W  = 11;
    localparam int unsigned OCOL_W = 7;
    localparam int unsigned OROW_W = 5;
    localparam int unsigned OADR_W = 11;
    localparam int unsigned CELL_W = CH_W + ATTR_W;

    // Character codes
    localparam logic [CH_W-1:0]   SPACE_CHAR      = 8'h20;
    localparam logic [CH_W-1:0]   LINE_FEED       = 8'h0A;
    localparam logic [CH_W-1:0]   CARRIAGE_RETURN = 8'h0D;
    localparam logic [ATTR_W-1:0] RESET_ATTR      = 8'h07;

    // Request opcodes
    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [CH_W-1:0]   char_code;
        logic [ATTR_W-1:0] char_attribute;
        logic [IDX_W-1:0]  cell_index;
    } t_in_req;

    typedef struct packed {
        logic [OCOL_W-1:0] cursor_column;
        logic [OROW_W-1:0] cursor_row;
        logic [OADR_W-1:0] cursor_address;
        logic [CELL_W-1:0] read_cell;
        logic              scrolled;
    } t_out_rsp;

    // Microprogram steps
    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_RD   = 8'b0000_0010,
        S_PUT  = 8'b0000_0100,
        S_CLR  = 8'b0000_1000,
        S_MV   = 8'b0001_0000,
        S_DRN  = 8'b0010_0000,
        S_FILL = 8'b0100_0000,
        S_FIN  = 8'b1000_0000
    } t_step;

    typedef enum logic [2:0] {
        M_NONE,
        M_CLR,
        M_PUT,
        M_MOVE,
        M_FILL
    } t_mem_op;

    typedef enum logic [1:0] {
        CN_HOLD,
        CN_INC,
        CN_LD_MOVE,
        CN_LD_FILL
    } t_cnt_op;

    typedef enum logic [1:0] {
        C_NONE,
        C_ACC,
        C_CNT_END,
        C_SCROLL
    } t_cond;

    typedef struct packed {
        logic    ready;
        logic    wait_out;
        logic    emit;
        logic    scr;
        logic    rd_res;
        logic    cur_upd;
        t_mem_op mem;
        t_cnt_op cnt;
        t_cond   cond;
        t_step   jump;
        t_step   nxt;
    } t_uword;

    // Status from the datapath to the sequencer
    typedef struct packed {
        logic accept;
        logic opcode;
        logic cnt_end;
        logic scroll;
        logic slot_free;
    } t_seq_cond;

    // Commands from the sequencer to the datapath, already gated
    typedef struct packed {
        logic    ready;
        logic    emit;
        logic    scr;
        logic    rd_res;
        logic    cur_upd;
        t_mem_op mem;
        t_cnt_op cnt;
    } t_ucmd;

    // Control store
    function automatic t_uword ucode(input t_step step);
        t_uword w;
        w = '{ready: 1'b0, wait_out: 1'b0, emit: 1'b0, scr: 1'b0, rd_res: 1'b0,
              cur_upd: 1'b0, mem: M_NONE, cnt: CN_HOLD, cond: C_NONE,
              jump: S_IDLE, nxt: S_IDLE};
        unique case (step)
            S_IDLE: begin
                w.ready = 1'b1;
                w.cond  = C_ACC;
            end
            S_RD: begin
                w.wait_out = 1'b1;
                w.emit     = 1'b1;
                w.rd_res   = 1'b1;
            end
            S_PUT: begin
                w.wait_out = 1'b1;
                w.emit     = 1'b1;
                w.cur_upd  = 1'b1;
                w.mem      = M_PUT;
                w.cnt      = CN_LD_MOVE;
                w.cond     = C_SCROLL;
                w.jump     = S_MV;
            end
            S_CLR: begin
                w.mem  = M_CLR;
                w.cnt  = CN_INC;
                w.cond = C_CNT_END;
                w.jump = S_IDLE;
                w.nxt  = S_CLR;
            end
            S_MV: begin
                w.mem  = M_MOVE;
                w.cnt  = CN_INC;
                w.cond = C_CNT_END;
                w.jump = S_DRN;
                w.nxt  = S_MV;
            end
            S_DRN: begin
                w.cnt = CN_LD_FILL;
                w.nxt = S_FILL;
            end
            S_FILL: begin
                w.mem  = M_FILL;
                w.cnt  = CN_INC;
                w.cond = C_CNT_END;
                w.jump = S_FIN;
                w.nxt  = S_FILL;
            end
            S_FIN: begin
                w.wait_out = 1'b1;
                w.emit     = 1'b1;
                w.scr      = 1'b1;
            end
            default: begin
                w.nxt = S_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

[sv/tcw_in_if.sv]
interface tcw_in_if;
    import tcw_pkg::*;

    logic    valid;
    logic    ready;
    t_in_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[sv/tcw_out_if.sv]
interface tcw_out_if;
    import tcw_pkg::*;

    logic     valid;
    logic     ready;
    t_out_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[sv/tcw_ram.sv]
module tcw_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[sv/tcw_seq.sv]
module tcw_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tcw_pkg::t_seq_cond i_cond,
    output tcw_pkg::t_ucmd     o_cmd
);
    import tcw_pkg::*;

    t_step  r_step;
    t_step  n_step;
    t_uword uw;
    logic   go;
    logic   take;

    assign uw = ucode(r_step);

    // A step that hands over a response waits for the output slot
    assign go = !(uw.wait_out && !i_cond.slot_free);

    always_comb begin
        unique case (uw.cond)
            C_CNT_END: take = i_cond.cnt_end;
            C_SCROLL:  take = i_cond.scroll;
            default:   take = 1'b0;
        endcase
    end

    // Next step: hold, dispatch, jump or fall through
    always_comb begin
        if (!go) begin
            n_step = r_step;
        end else if (uw.cond == C_ACC) begin
            if (!i_cond.accept) begin
                n_step = r_step;
            end else if (i_cond.opcode == OP_READ) begin
                n_step = S_RD;
            end else begin
                n_step = S_PUT;
            end
        end else if (take) begin
            n_step = uw.jump;
        end else begin
            n_step = uw.nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_CLR;
        end else begin
            r_step <= n_step;
        end
    end

    // Commands are suppressed while the step waits, and emit also when the step jumps
    always_comb begin
        o_cmd.ready   = uw.ready;
        o_cmd.emit    = uw.emit && go && !take;
        o_cmd.scr     = uw.scr;
        o_cmd.rd_res  = uw.rd_res;
        o_cmd.cur_upd = uw.cur_upd && go;
        o_cmd.mem     = go ? uw.mem : M_NONE;
        o_cmd.cnt     = go ? uw.cnt : CN_HOLD;
    end
endmodule

[sv/text_console_writer.sv]
// Put request: capture, then cell write and cursor update.
// Read request: capture with memory read, then response.
// In a put that scrolls, the single write port moves one cell a cycle and then writes the
// blank bottom row.
// Reset (synchronous, active low) clears the cursor and then sweeps all ROWS*COLUMNS cells to
// blanks, one a cycle; no request is taken during that pass, config writes are.
module text_console_writer #(
    parameter int unsigned COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int unsigned ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    tcw_in_if.sink                      i_req,
    tcw_out_if.source                   o_rsp,
    input  logic                        i_cfg_we,
    input  logic [tcw_pkg::ATTR_W-1:0]  i_cfg_data
);
    import tcw_pkg::*;

    localparam int unsigned CELLS      = ROWS * COLUMNS;
    localparam int unsigned ADDR_W     = $clog2(CELLS);
    localparam int unsigned COL_W      = $clog2(COLUMNS);
    localparam int unsigned ROW_W      = $clog2(ROWS);
    localparam int unsigned FILL_START = (ROWS - 1) * COLUMNS;

    t_seq_cond cond;
    t_ucmd     cmd;

    logic [ATTR_W-1:0] r_blank_attr;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [ADDR_W-1:0] r_base;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] r_cnt;
    logic [ADDR_W-1:0] r_idx;
    logic              r_in_range;
    logic [CH_W-1:0]   r_ch;
    logic [ATTR_W-1:0] r_attr;
    logic              r_wr_pend;
    logic [ADDR_W-1:0] r_wr_addr;
    logic              r_ov;
    t_out_rsp          r_rsp;

    logic [COL_W-1:0]  n_col;
    logic [ROW_W-1:0]  n_row;
    logic [ADDR_W-1:0] n_base;
    logic [ADDR_W-1:0] n_addr;

    logic              accept;
    logic              newline;
    logic              wrap;
    logic              last_row;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [CELL_W-1:0] mem_rdata;

    tcw_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cond  (cond),
        .o_cmd   (cmd)
    );

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Handshake
    assign i_req.ready   = cmd.ready;
    assign accept        = i_req.valid && cmd.ready;
    assign o_rsp.valid   = r_ov;
    assign o_rsp.payload = r_rsp;

    // Cursor advance
    assign newline  = (r_ch == LINE_FEED) || (r_ch == CARRIAGE_RETURN);
    assign wrap     = newline || (r_col == COL_W'(COLUMNS - 1));
    assign last_row = (r_row == ROW_W'(ROWS - 1));

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_base = r_base;
        n_addr = r_addr;
        if (cmd.cur_upd) begin
            if (wrap) begin
                n_col = '0;
                if (!last_row) begin
                    n_row  = r_row + ROW_W'(1);
                    n_base = r_base + ADDR_W'(COLUMNS);
                end
                n_addr = n_base;
            end else begin
                n_col  = r_col + COL_W'(1);
                n_addr = r_addr + ADDR_W'(1);
            end
        end
    end

    // Sequencer status
    always_comb begin
        cond.accept    = accept;
        cond.opcode    = i_req.payload.opcode;
        cond.cnt_end   = (r_cnt == ADDR_W'(CELLS - 1));
        cond.scroll    = wrap && last_row;
        cond.slot_free = !r_ov || o_rsp.ready;
    end

    // Memory port muxing; a pending move write owns the write port
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_cnt;
        mem_wdata = {RESET_ATTR, SPACE_CHAR};
        if (r_wr_pend) begin
            mem_we    = 1'b1;
            mem_waddr = r_wr_addr;
            mem_wdata = mem_rdata;
        end else begin
            case (cmd.mem)
                M_CLR: begin
                    mem_we = 1'b1;
                end
                M_FILL: begin
                    mem_we    = 1'b1;
                    mem_wdata = {r_blank_attr, SPACE_CHAR};
                end
                M_PUT: begin
                    mem_we    = !newline;
                    mem_waddr = r_addr;
                    mem_wdata = {r_attr, r_ch};
                end
                default: begin
                    mem_we = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        if (cmd.mem == M_MOVE) begin
            mem_raddr = r_cnt;
        end else if (cmd.ready) begin
            mem_raddr = ADDR_W'(i_req.payload.cell_index);
        end else begin
            mem_raddr = r_idx;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blank_attr <= RESET_ATTR;
            r_col        <= '0;
            r_row        <= '0;
            r_base       <= '0;
            r_addr       <= '0;
            r_cnt        <= '0;
            r_wr_pend    <= 1'b0;
            r_ov         <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_blank_attr <= i_cfg_data;
            end
            r_col     <= n_col;
            r_row     <= n_row;
            r_base    <= n_base;
            r_addr    <= n_addr;
            r_wr_pend <= (cmd.mem == M_MOVE);
            unique case (cmd.cnt)
                CN_INC:     r_cnt <= r_cnt + ADDR_W'(1);
                CN_LD_MOVE: r_cnt <= ADDR_W'(COLUMNS);
                CN_LD_FILL: r_cnt <= ADDR_W'(FILL_START);
                default:    r_cnt <= r_cnt;
            endcase
            if (cmd.emit) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Request capture, move pipeline and response payload
    always_ff @(posedge i_clk) begin
        r_wr_addr <= r_cnt - ADDR_W'(COLUMNS);
        if (accept) begin
            r_ch       <= i_req.payload.char_code;
            r_attr     <= i_req.payload.char_attribute;
            r_idx      <= ADDR_W'(i_req.payload.cell_index);
            r_in_range <= (32'(i_req.payload.cell_index) < 32'(CELLS));
        end
        if (cmd.emit) begin
            r_rsp.cursor_column  <= OCOL_W'(n_col);
            r_rsp.cursor_row     <= OROW_W'(n_row);
            r_rsp.cursor_address <= OADR_W'(n_addr);
            r_rsp.read_cell      <= (cmd.rd_res && r_in_range) ? mem_rdata : '0;
            r_rsp.scrolled       <= cmd.scr;
        end
    end

    // The move pipeline never collides with a sequencer write
    a_no_wr_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_pend |-> !(cmd.mem == M_CLR || cmd.mem == M_FILL || cmd.mem == M_PUT))
        else $error("move write collides with another memory write");

    // Cursor address tracks row base plus column
    a_addr_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_addr == r_base + ADDR_W'(r_col))
        else $error("cursor address out of step with row and column");

    // No request is taken while a scroll write is still in flight
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.ready |-> !r_wr_pend)
        else $error("request accepted during a scroll");

    // A scrolled response leaves the cursor at column 0 of the last row
    a_scroll_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit && cmd.scr) |=> (r_row == ROW_W'(ROWS - 1) && r_col == '0))
        else $error("cursor misplaced after scroll");
endmodule
